>>> rtl/nbgs_pkg.sv
package nbgs_pkg;

	localparam int WORD_W = 32;

	// configuration register indexes
	localparam logic [1:0] CFG_GRAVITY   = 2'd0;
	localparam logic [1:0] CFG_TIME_STEP = 2'd1;
	localparam logic [1:0] CFG_SUBSTEPS  = 2'd2;

	localparam logic [31:0] RST_GRAVITY   = 32'd65536;
	localparam logic [31:0] RST_TIME_STEP = 32'd1092;
	localparam logic [4:0]  RST_SUBSTEPS  = 5'd5;

	localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [WORD_W-1:0] mass;
		logic [WORD_W-1:0] vel_y;
		logic [WORD_W-1:0] vel_x;
		logic [WORD_W-1:0] pos_y;
		logic [WORD_W-1:0] pos_x;
	} body_t;

	// 33-bit two's complement value clamped to 32 bits
	function automatic logic [31:0] sat33(input logic [32:0] v);
		if (v[32] != v[31]) begin
			return v[32] ? S32_MIN : S32_MAX;
		end
		return v[31:0];
	endfunction

	// signed value from sign and magnitude, clamped to 32 bits
	function automatic logic [31:0] ssat(input logic neg, input logic [63:0] m);
		logic [63:0] nm;
		nm = 64'd0 - m;
		if (neg) begin
			return (m > 64'h8000_0000) ? S32_MIN : nm[31:0];
		end
		return (m > 64'h7fff_ffff) ? S32_MAX : m[31:0];
	endfunction

	// magnitude of a force after signed clamping
	function automatic logic [31:0] fclamp(input logic neg, input logic [31:0] q);
		if (neg) begin
			return (q > S32_MIN) ? S32_MIN : q;
		end
		return (q > S32_MAX) ? S32_MAX : q;
	endfunction

	function automatic logic [32:0] sx33(input logic [31:0] x);
		return {x[31], x};
	endfunction

endpackage

>>> rtl/nbgs_body_mem.sv
module nbgs_body_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  nbgs_pkg::body_t      wdata,
	input  logic [AW-1:0]        raddr,
	output nbgs_pkg::body_t      rdata
);

	nbgs_pkg::body_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/nbgs_divu.sv
// restoring divider, one quotient bit per cycle, quotient clamped to 32 bits
module nbgs_divu #(
	parameter int NW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [63:0]   den,
	output logic          busy,
	output logic [31:0]   quo
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] den_q;
	logic [31:0] quo_q;
	logic [63:0] hi;
	logic [64:0] trial;
	logic [64:0] diff;
	logic        ge;

	assign hi    = 64'(num[NW-1:32]);
	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= hi < den;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= hi;
			quo_q <= (hi >= den) ? 32'hffff_ffff : num[31:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[63:0] : trial[63:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

>>> rtl/nbgs_isqrt.sv
// digit-by-digit integer square root, two radicand bits per cycle
module nbgs_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] val,
	output logic        busy,
	output logic [31:0] root
);

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [63:0] v_q;
	logic [34:0] rem_q;
	logic [31:0] root_q;
	logic [36:0] rem2;
	logic [36:0] trial;
	logic [36:0] diff;
	logic        ge;

	assign rem2  = {rem_q, v_q[63:62]};
	assign trial = {3'b000, root_q, 2'b01};
	assign diff  = rem2 - trial;
	assign ge    = rem2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= val;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[61:0], 2'b00};
			rem_q  <= ge ? diff[34:0] : rem2[34:0];
			root_q <= {root_q[30:0], ge};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

>>> rtl/nbody_gravity_step_2d_top.sv
// All-pairs 2D gravity integrator, semi-implicit Euler, signed fixed point.
// Input stream: one word per body, tdata = pos_x, pos_y, vel_x, vel_y, mass.
// The word with tlast set closes the load and starts a run over the stored
// bodies; words past MAX_BODIES are dropped but their tlast still counts.
// Output stream: one word per body in load order, tlast on the final one.
// Config channel: index 0 gravity, 1 time step, 2 substep count; write only
// while the block is idle.
// Loading takes one word per cycle. Each pair reads two body entries and,
// unless they coincide, writes both back; its cost is set by the shared
// radix-2 divider (seven divides) and the square root. Each output word is
// read from the body memory and registered, then held until m_tready. One
// run is handled at a time: s_tready is low from the last input word until
// the last output word goes. Reset clears the sequencer and the load count
// and sets the config registers to their reset values; the body memory is
// not cleared. A stalled receiver holds the output word and the run simply
// waits.
module nbody_gravity_step_2d_top #(
	parameter int MAX_BODIES = 64,
	parameter int FRAC_BITS  = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [159:0] s_tdata,  // pos_x, pos_y, vel_x, vel_y, mass
	input  logic         s_tlast,  // last_body
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,  // body_index(6), new_pos_x, new_pos_y,
	                               // new_vel_x, new_vel_y, 2 zero bits
	output logic         m_tlast,  // last_result
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int IW = $clog2(MAX_BODIES);
	localparam int CW = $clog2(MAX_BODIES + 1);
	localparam int NW = (2 * FRAC_BITS > 32) ? 32 + 2 * FRAC_BITS : 64;

	localparam logic [5:0] ST_LOAD  = 6'd0;
	localparam logic [5:0] ST_SDT   = 6'd1;
	localparam logic [5:0] ST_DIVW  = 6'd2;
	localparam logic [5:0] ST_SDTL  = 6'd3;
	localparam logic [5:0] ST_SUB   = 6'd4;
	localparam logic [5:0] ST_PRDI  = 6'd5;
	localparam logic [5:0] ST_PRDJ  = 6'd6;
	localparam logic [5:0] ST_PLATJ = 6'd7;
	localparam logic [5:0] ST_POFS  = 6'd8;
	localparam logic [5:0] ST_PMXX  = 6'd9;
	localparam logic [5:0] ST_PMYY  = 6'd10;
	localparam logic [5:0] ST_PSUM  = 6'd11;
	localparam logic [5:0] ST_PGM   = 6'd12;
	localparam logic [5:0] ST_PGMM  = 6'd13;
	localparam logic [5:0] ST_PGMS  = 6'd14;
	localparam logic [5:0] ST_PSQ   = 6'd15;
	localparam logic [5:0] ST_PSQW  = 6'd16;
	localparam logic [5:0] ST_PDMAG = 6'd17;
	localparam logic [5:0] ST_PFXM  = 6'd18;
	localparam logic [5:0] ST_PFXD  = 6'd19;
	localparam logic [5:0] ST_PFYM  = 6'd20;
	localparam logic [5:0] ST_PFYD  = 6'd21;
	localparam logic [5:0] ST_PPX   = 6'd22;
	localparam logic [5:0] ST_PDXI  = 6'd23;
	localparam logic [5:0] ST_PDXJ  = 6'd24;
	localparam logic [5:0] ST_PMULY = 6'd25;
	localparam logic [5:0] ST_PDYI  = 6'd26;
	localparam logic [5:0] ST_PDYJ  = 6'd27;
	localparam logic [5:0] ST_PWRI  = 6'd28;
	localparam logic [5:0] ST_PWRJ  = 6'd29;
	localparam logic [5:0] ST_PNXT  = 6'd30;
	localparam logic [5:0] ST_ARD   = 6'd31;
	localparam logic [5:0] ST_ALAT  = 6'd32;
	localparam logic [5:0] ST_AMX   = 6'd33;
	localparam logic [5:0] ST_AMY   = 6'd34;
	localparam logic [5:0] ST_AWR   = 6'd35;
	localparam logic [5:0] ST_ORD   = 6'd36;
	localparam logic [5:0] ST_OLD   = 6'd37;
	localparam logic [5:0] ST_OWT   = 6'd38;

	// control
	logic [5:0]    state_q;
	logic [5:0]    ret_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] n_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] j_q;
	logic [4:0]    sub_q;
	logic [31:0]   gravity_q;
	logic [31:0]   time_step_q;
	logic [4:0]    substeps_q;
	logic          m_tvalid_q;

	// datapath
	nbgs_pkg::body_t bi_q;
	nbgs_pkg::body_t bj_q;
	nbgs_pkg::body_t rd;
	nbgs_pkg::body_t in_body;
	logic [31:0]   sdt_q;
	logic [31:0]   ax_q;
	logic [31:0]   ay_q;
	logic          negx_q;
	logic          negy_q;
	logic [63:0]   mul_q;
	logic [63:0]   sqx_q;
	logic [63:0]   d2_q;
	logic [31:0]   gmm_q;
	logic [31:0]   mag_q;
	logic [31:0]   fxm_q;
	logic [31:0]   fym_q;
	logic [31:0]   dxi_q;
	logic [31:0]   dxj_q;
	logic [31:0]   dyi_q;
	logic [31:0]   nx_q;
	logic [135:0]  m_tdata_q;
	logic          m_tlast_q;

	// comb
	logic            s_acc;
	logic            room;
	logic [4:0]      subs;
	logic            mem_we;
	logic [IW-1:0]   mem_waddr;
	logic [IW-1:0]   mem_raddr;
	nbgs_pkg::body_t mem_wdata;
	logic            mul_en;
	logic [31:0]     mul_a;
	logic [31:0]     mul_b;
	logic            div_start;
	logic [NW-1:0]   div_num;
	logic [63:0]     div_den;
	logic            div_busy;
	logic [31:0]     quo;
	logic            sq_start;
	logic            sq_busy;
	logic [31:0]     sq_root;
	logic [31:0]     ox;
	logic [31:0]     oy;
	logic [63:0]     d2_sum;
	logic [31:0]     gmsat;
	logic [31:0]     magc;
	logic [31:0]     avx;
	logic [31:0]     avy;
	logic [63:0]     adv;
	logic [31:0]     vxi_new;
	logic [31:0]     vyi_new;
	logic [31:0]     vxj_new;
	logic [31:0]     vyj_new;
	logic [31:0]     nx;
	logic [31:0]     ny;
	logic            i_last;
	logic            j_last;
	logic            i_penult;

	assign s_acc    = s_tvalid && s_tready;
	assign room     = cnt_q < CW'(MAX_BODIES);
	assign s_tready = state_q == ST_LOAD;
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	assign subs = (substeps_q == 5'd0) ? 5'd1 :
	              ((substeps_q > 5'd16) ? 5'd16 : substeps_q);

	assign in_body.pos_x = s_tdata[31:0];
	assign in_body.pos_y = s_tdata[63:32];
	assign in_body.vel_x = s_tdata[95:64];
	assign in_body.vel_y = s_tdata[127:96];
	assign in_body.mass  = (s_tdata[159:128] == 32'd0) ? 32'd1 : s_tdata[159:128];

	assign i_last   = CW'(i_q) == n_q - CW'(1);
	assign j_last   = CW'(j_q) == n_q - CW'(1);
	assign i_penult = CW'(i_q) == n_q - CW'(2);

	assign ox     = nbgs_pkg::sat33(nbgs_pkg::sx33(bi_q.pos_x) - nbgs_pkg::sx33(bj_q.pos_x));
	assign oy     = nbgs_pkg::sat33(nbgs_pkg::sx33(bi_q.pos_y) - nbgs_pkg::sx33(bj_q.pos_y));
	assign d2_sum = sqx_q + mul_q;
	assign gmsat  = (|mul_q[63:32+FRAC_BITS]) ? 32'hffff_ffff
	                                          : mul_q[31+FRAC_BITS:FRAC_BITS];
	assign magc   = quo[31] ? nbgs_pkg::S32_MAX : quo;
	assign avx    = bi_q.vel_x[31] ? 32'd0 - bi_q.vel_x : bi_q.vel_x;
	assign avy    = bi_q.vel_y[31] ? 32'd0 - bi_q.vel_y : bi_q.vel_y;
	assign adv    = mul_q >> FRAC_BITS;

	// force on i points against the offset, on j along it
	assign vxi_new = nbgs_pkg::sat33(nbgs_pkg::sx33(bi_q.vel_x)
		- nbgs_pkg::sx33(nbgs_pkg::ssat(negx_q, 64'(dxi_q))));
	assign vyi_new = nbgs_pkg::sat33(nbgs_pkg::sx33(bi_q.vel_y)
		- nbgs_pkg::sx33(nbgs_pkg::ssat(negy_q, 64'(dyi_q))));
	assign vxj_new = nbgs_pkg::sat33(nbgs_pkg::sx33(bj_q.vel_x)
		+ nbgs_pkg::sx33(nbgs_pkg::ssat(negx_q, 64'(dxj_q))));
	assign vyj_new = nbgs_pkg::sat33(nbgs_pkg::sx33(bj_q.vel_y)
		+ nbgs_pkg::sx33(nbgs_pkg::ssat(negy_q, 64'(quo))));
	assign nx = nbgs_pkg::sat33(nbgs_pkg::sx33(bi_q.pos_x)
		+ nbgs_pkg::sx33(nbgs_pkg::ssat(bi_q.vel_x[31], adv)));
	assign ny = nbgs_pkg::sat33(nbgs_pkg::sx33(bi_q.pos_y)
		+ nbgs_pkg::sx33(nbgs_pkg::ssat(bi_q.vel_y[31], adv)));

	nbgs_body_mem #(
		.DEPTH(MAX_BODIES),
		.AW   (IW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rd)
	);

	nbgs_divu #(
		.NW(NW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.quo   (quo)
	);

	nbgs_isqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.val   (d2_q),
		.busy  (sq_busy),
		.root  (sq_root)
	);

	// memory port, multiplier and divider operand steering, square root start
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = i_q;
		mem_wdata = bi_q;
		mem_raddr = (state_q == ST_PRDJ) ? j_q : i_q;
		mul_en    = 1'b0;
		mul_a     = sdt_q;
		mul_b     = fxm_q;
		div_start = 1'b0;
		div_num   = NW'(mul_q);
		div_den   = 64'(sq_root);
		sq_start  = 1'b0;
		unique case (state_q) inside
			ST_LOAD: begin
				mem_we    = s_acc && room;
				mem_waddr = cnt_q[IW-1:0];
				mem_wdata = in_body;
			end
			ST_SDT: begin
				div_start = 1'b1;
				div_num   = NW'(time_step_q);
				div_den   = 64'(subs);
			end
			ST_PMXX: begin
				mul_en = 1'b1;
				mul_a  = ax_q;
				mul_b  = ax_q;
			end
			ST_PMYY: begin
				mul_en = 1'b1;
				mul_a  = ay_q;
				mul_b  = ay_q;
			end
			ST_PGM: begin
				mul_en = 1'b1;
				mul_a  = gravity_q;
				mul_b  = bi_q.mass;
			end
			ST_PGMM: begin
				mul_en = 1'b1;
				mul_a  = gmsat;
				mul_b  = bj_q.mass;
			end
			ST_PSQ: sq_start = 1'b1;
			ST_PDMAG: begin
				div_start = 1'b1;
				div_num   = NW'({gmm_q, {(2 * FRAC_BITS){1'b0}}});
				div_den   = d2_q;
			end
			ST_PFXM: begin
				mul_en = 1'b1;
				mul_a  = magc;
				mul_b  = ax_q;
			end
			ST_PFXD, ST_PFYD: div_start = 1'b1;
			ST_PFYM: begin
				mul_en = 1'b1;
				mul_a  = mag_q;
				mul_b  = ay_q;
			end
			ST_PPX: begin
				mul_en = 1'b1;
				mul_b  = nbgs_pkg::fclamp(negx_q, fxm_q);
			end
			ST_PDXI, ST_PDYI: begin
				div_start = 1'b1;
				div_den   = 64'(bi_q.mass);
			end
			ST_PDXJ, ST_PDYJ: begin
				div_start = 1'b1;
				div_den   = 64'(bj_q.mass);
			end
			ST_PMULY: begin
				mul_en = 1'b1;
				mul_b  = fym_q;
			end
			ST_PWRI: begin
				mem_we    = 1'b1;
				mem_wdata = '{mass: bi_q.mass, vel_y: vyi_new, vel_x: vxi_new,
				              pos_y: bi_q.pos_y, pos_x: bi_q.pos_x};
			end
			ST_PWRJ: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				mem_wdata = '{mass: bj_q.mass, vel_y: vyj_new, vel_x: vxj_new,
				              pos_y: bj_q.pos_y, pos_x: bj_q.pos_x};
			end
			ST_AMX: begin
				mul_en = 1'b1;
				mul_b  = avx;
			end
			ST_AMY: begin
				mul_en = 1'b1;
				mul_b  = avy;
			end
			ST_AWR: begin
				mem_we    = 1'b1;
				mem_wdata = '{mass: bi_q.mass, vel_y: bi_q.vel_y, vel_x: bi_q.vel_x,
				              pos_y: ny, pos_x: nx_q};
			end
			default: ;
		endcase
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q   <= nbgs_pkg::RST_GRAVITY;
			time_step_q <= nbgs_pkg::RST_TIME_STEP;
			substeps_q  <= nbgs_pkg::RST_SUBSTEPS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				nbgs_pkg::CFG_GRAVITY:   gravity_q   <= cfg_data;
				nbgs_pkg::CFG_TIME_STEP: time_step_q <= cfg_data;
				nbgs_pkg::CFG_SUBSTEPS:  substeps_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			ret_q      <= ST_LOAD;
			cnt_q      <= '0;
			n_q        <= '0;
			i_q        <= '0;
			j_q        <= '0;
			sub_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (s_acc) begin
						if (s_tlast) begin
							n_q     <= room ? cnt_q + CW'(1) : cnt_q;
							cnt_q   <= '0;
							state_q <= ST_SDT;
						end else if (room) begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				ST_SDT: begin
					ret_q   <= ST_SDTL;
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (!div_busy) begin
						state_q <= ret_q;
					end
				end
				ST_SDTL: begin
					sub_q   <= '0;
					state_q <= ST_SUB;
				end
				ST_SUB: begin
					i_q     <= '0;
					j_q     <= IW'(1);
					state_q <= (n_q == CW'(1)) ? ST_ARD : ST_PRDI;
				end
				ST_PRDI:  state_q <= ST_PRDJ;
				ST_PRDJ:  state_q <= ST_PLATJ;
				ST_PLATJ: state_q <= ST_POFS;
				ST_POFS:  state_q <= ST_PMXX;
				ST_PMXX:  state_q <= ST_PMYY;
				ST_PMYY:  state_q <= ST_PSUM;
				// coincident bodies exert no force
				ST_PSUM:  state_q <= (d2_sum == 64'd0) ? ST_PNXT : ST_PGM;
				ST_PGM:   state_q <= ST_PGMM;
				ST_PGMM:  state_q <= ST_PGMS;
				ST_PGMS:  state_q <= ST_PSQ;
				ST_PSQ:   state_q <= ST_PSQW;
				ST_PSQW: begin
					if (!sq_busy) begin
						state_q <= ST_PDMAG;
					end
				end
				ST_PDMAG: begin
					ret_q   <= ST_PFXM;
					state_q <= ST_DIVW;
				end
				ST_PFXM: state_q <= ST_PFXD;
				ST_PFXD: begin
					ret_q   <= ST_PFYM;
					state_q <= ST_DIVW;
				end
				ST_PFYM: state_q <= ST_PFYD;
				ST_PFYD: begin
					ret_q   <= ST_PPX;
					state_q <= ST_DIVW;
				end
				ST_PPX: state_q <= ST_PDXI;
				ST_PDXI: begin
					ret_q   <= ST_PDXJ;
					state_q <= ST_DIVW;
				end
				ST_PDXJ: begin
					ret_q   <= ST_PMULY;
					state_q <= ST_DIVW;
				end
				ST_PMULY: state_q <= ST_PDYI;
				ST_PDYI: begin
					ret_q   <= ST_PDYJ;
					state_q <= ST_DIVW;
				end
				ST_PDYJ: begin
					ret_q   <= ST_PWRI;
					state_q <= ST_DIVW;
				end
				ST_PWRI: state_q <= ST_PWRJ;
				ST_PWRJ: state_q <= ST_PNXT;
				ST_PNXT: begin
					if (j_last) begin
						if (i_penult) begin
							i_q     <= '0;
							state_q <= ST_ARD;
						end else begin
							i_q     <= i_q + IW'(1);
							j_q     <= i_q + IW'(2);
							state_q <= ST_PRDI;
						end
					end else begin
						j_q     <= j_q + IW'(1);
						state_q <= ST_PRDI;
					end
				end
				ST_ARD:  state_q <= ST_ALAT;
				ST_ALAT: state_q <= ST_AMX;
				ST_AMX:  state_q <= ST_AMY;
				ST_AMY:  state_q <= ST_AWR;
				ST_AWR: begin
					if (i_last) begin
						i_q <= '0;
						if (sub_q + 5'd1 == subs) begin
							state_q <= ST_ORD;
						end else begin
							sub_q   <= sub_q + 5'd1;
							state_q <= ST_SUB;
						end
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= ST_ARD;
					end
				end
				ST_ORD: state_q <= ST_OLD;
				ST_OLD: begin
					m_tvalid_q <= 1'b1;
					state_q    <= ST_OWT;
				end
				ST_OWT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (i_last) begin
							i_q     <= '0;
							state_q <= ST_LOAD;
						end else begin
							i_q     <= i_q + IW'(1);
							state_q <= ST_ORD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (mul_en) begin
			mul_q <= mul_a * mul_b;
		end
		case (state_q)
			ST_SDTL:  sdt_q <= quo;
			ST_PRDJ:  bi_q  <= rd;
			ST_PLATJ: bj_q  <= rd;
			ST_POFS: begin
				negx_q <= ox[31];
				negy_q <= oy[31];
				ax_q   <= ox[31] ? 32'd0 - ox : ox;
				ay_q   <= oy[31] ? 32'd0 - oy : oy;
			end
			ST_PMYY:  sqx_q <= mul_q;
			ST_PSUM:  d2_q  <= d2_sum;
			ST_PGMS:  gmm_q <= gmsat;
			ST_PFXM:  mag_q <= magc;
			ST_PFYM:  fxm_q <= quo;
			ST_PPX: begin
				fxm_q <= nbgs_pkg::fclamp(negx_q, fxm_q);
				fym_q <= nbgs_pkg::fclamp(negy_q, quo);
			end
			ST_PDXJ:  dxi_q <= quo;
			ST_PMULY: dxj_q <= quo;
			ST_PDYJ:  dyi_q <= quo;
			ST_ALAT:  bi_q  <= rd;
			ST_AMY:   nx_q  <= nx;
			ST_OLD: begin
				m_tdata_q <= {2'b00, rd.vel_y, rd.vel_x, rd.pos_y, rd.pos_x, 6'(i_q)};
				m_tlast_q <= i_last;
			end
			default: ;
		endcase
	end

	// input and output never open at the same time
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output open together");

	// the final output word hands the block back to loading
	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("not back to load after final word");

	// the square root and the divider never run at once
	a_units_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_busy && sq_busy))
		else $error("divider and square root overlap");

endmodule
